[design/fr_fcfs_bank_queue_scheduler_macros.svh]
// Assertion helpers for the bank queue scheduler
`ifndef FR_FCFS_BANK_QUEUE_SCHEDULER_MACROS_SVH
`define FR_FCFS_BANK_QUEUE_SCHEDULER_MACROS_SVH
// implication checked every clock, off during reset
`define FBQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define FBQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/fbq_pkg.sv]
// ----------------------------------------------------------------------------
// fbq_pkg: shared codes and types
// Operation and status codes of the bank queue scheduler.
// ----------------------------------------------------------------------------
package fbq_pkg;
    typedef enum logic [2:0] {
        MODE_STORE  = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_SELECT = 3'd2,
        MODE_ROWQ   = 3'd3,
        MODE_REQQ   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } fsm_t;

    localparam int unsigned MIN_FURTHER = 2;
endpackage

[design/fbq_cell.sv]
// ----------------------------------------------------------------------------
// fbq_cell: one queue slot of one bank
// Holds row and tag; compares against the command and can take its
// younger neighbor's contents when it or an entry ahead of it is removed.
// ----------------------------------------------------------------------------
module fbq_cell
    import fbq_pkg::*;
#(
    parameter int ROW_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  logic                aclk,
    input  logic                load,
    input  logic                shift,
    input  logic [ROW_BITS-1:0] load_row,
    input  logic [TAG_BITS-1:0] load_tag,
    input  logic [ROW_BITS-1:0] nb_row,
    input  logic [TAG_BITS-1:0] nb_tag,
    input  logic [ROW_BITS-1:0] cmp_row,
    input  logic [TAG_BITS-1:0] cmp_tag,
    output logic [ROW_BITS-1:0] row,
    output logic [TAG_BITS-1:0] tag,
    output logic                row_hit,
    output logic                tag_hit
);
    logic [ROW_BITS-1:0] row_reg;
    logic [TAG_BITS-1:0] tag_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= load_row;
            tag_reg <= load_tag;
        end else if (shift) begin
            row_reg <= nb_row;
            tag_reg <= nb_tag;
        end
    end

    assign row     = row_reg;
    assign tag     = tag_reg;
    assign row_hit = (row_reg == cmp_row);
    assign tag_hit = (tag_reg == cmp_tag);
endmodule

[design/fr_fcfs_bank_queue_scheduler.sv]
// Flow: an input beat is captured in idle, executed into the result register, and
// the result beat holds until m_ready; the block holds one item at a time while a
// bank's chain of slot cells is searched and shifted in the execute state.
// Reset: synchronous active low aresetn clears all counts and control; cell
// contents need no reset since only slots below a bank's count are read.
// ----------------------------------------------------------------------------
// fr_fcfs_bank_queue_scheduler: per-bank FR-FCFS request queues
// Each bank owns a chain of QUEUE_DEPTH cells, oldest at slot 0. Store
// loads the slot at the count; remove shifts younger cells up one slot.
// ----------------------------------------------------------------------------
`include "fr_fcfs_bank_queue_scheduler_macros.svh"
module fr_fcfs_bank_queue_scheduler
    import fbq_pkg::*;
#(
    parameter int BANKS       = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ROW_BITS    = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [3:0]  s_bank_index,
    input  logic [15:0] s_row_address,
    input  logic [7:0]  s_request_tag,
    input  logic        s_bank_is_open,
    input  logic [15:0] s_open_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_chosen_tag,
    output logic [15:0] m_chosen_row,
    output logic        m_query_true
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;

    // control
    fsm_t state_reg, state_next;

    // captured command
    logic [2:0]          mode_reg;
    logic [3:0]          bank_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                open_reg;
    logic [ROW_BITS-1:0] orow_reg;

    // result register
    logic [1:0]  status_reg, status_next;
    logic [7:0]  ctag_reg, ctag_next;
    logic [15:0] crow_reg, crow_next;
    logic        qt_reg, qt_next;

    logic [CW-1:0] count_reg [BANKS];

    // cell array: bank x slot
    logic [ROW_BITS-1:0] c_row [BANKS][QUEUE_DEPTH];
    logic [TAG_BITS-1:0] c_tag [BANKS][QUEUE_DEPTH];
    logic                c_rhit [BANKS][QUEUE_DEPTH];
    logic                c_thit [BANKS][QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] load_v [BANKS];
    logic [QUEUE_DEPTH-1:0] shift_v [BANKS];

    // command compare values: select compares the open row
    logic [ROW_BITS-1:0] cmp_row;
    assign cmp_row = (mode_reg == MODE_SELECT) ? orow_reg : row_reg;

    logic bank_ok;
    assign bank_ok = ({28'd0, bank_reg} < BANKS);

    logic [BW-1:0] bsel;
    assign bsel = bank_ok ? BW'(bank_reg) : '0;

    logic exec;
    assign exec = (state_reg == S_EXEC);

    // per-slot view of the addressed bank
    logic [CW-1:0]          cnt;
    logic [QUEUE_DEPTH-1:0] live, rhit, thit, rm_after, row_first, row_after;

    always_comb begin
        cnt = count_reg[bsel];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            live[i] = (CW'(i) < cnt);
            rhit[i] = live[i] && c_rhit[bsel][i];
            thit[i] = live[i] && c_thit[bsel][i];
        end
        // oldest match priority: handed down the chain slot to slot
        rm_after     = '0;
        row_first    = '0;
        row_after    = '0;
        rm_after[0]  = thit[0];
        row_first[0] = rhit[0];
        row_after[0] = rhit[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            row_first[i] = rhit[i] && !row_after[i-1];
            row_after[i] = row_after[i-1] || rhit[i];
            rm_after[i]  = rm_after[i-1] || thit[i];
        end
    end

    logic [SW-1:0] pick;
    logic          any_hit;
    always_comb begin
        pick    = '0;
        any_hit = |row_first;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (row_first[i]) begin
                pick = SW'(i);
            end
        end
        if (!open_reg) begin
            pick = '0;
        end
    end

    logic [$clog2(QUEUE_DEPTH+1):0] hits;
    always_comb begin
        hits = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hits = hits + {{$clog2(QUEUE_DEPTH+1){1'b0}}, rhit[i]};
        end
    end

    logic do_store, do_remove;
    assign do_store  = exec && (mode_reg == MODE_STORE) && bank_ok &&
                       (cnt < CW'(QUEUE_DEPTH));
    assign do_remove = exec && (mode_reg == MODE_REMOVE) && bank_ok && (|thit);

    // cell chain: slot i takes slot i+1 when the match lies at or before i
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
            assign load_v[b][i] = do_store && (bsel == BW'(b)) && (cnt == CW'(i));
            if (i < QUEUE_DEPTH - 1) begin : g_sh
                assign shift_v[b][i] = do_remove && (bsel == BW'(b)) && rm_after[i] &&
                                       live[i+1];
            end else begin : g_sh_last
                assign shift_v[b][i] = 1'b0;
            end
            fbq_cell #(.ROW_BITS(ROW_BITS), .TAG_BITS(TAG_BITS)) u_cell (
                .aclk     (aclk),
                .load     (load_v[b][i]),
                .shift    (shift_v[b][i]),
                .load_row (row_reg),
                .load_tag (tag_reg),
                .nb_row   (c_row[b][(i + 1) % QUEUE_DEPTH]),
                .nb_tag   (c_tag[b][(i + 1) % QUEUE_DEPTH]),
                .cmp_row  (cmp_row),
                .cmp_tag  (tag_reg),
                .row      (c_row[b][i]),
                .tag      (c_tag[b][i]),
                .row_hit  (c_rhit[b][i]),
                .tag_hit  (c_thit[b][i])
            );
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // result
    always_comb begin
        status_next = ST_OK;
        ctag_next   = '0;
        crow_next   = '0;
        qt_next     = 1'b0;
        case (mode_reg)
            MODE_STORE: begin
                if (!do_store) status_next = ST_FULL;
            end
            MODE_REMOVE: begin
                if (!do_remove) status_next = ST_NOT_FOUND;
            end
            MODE_SELECT: begin
                if (!bank_ok || cnt == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    ctag_next = 8'(c_tag[bsel][(open_reg && any_hit) ? pick : '0]);
                    crow_next = 16'(c_row[bsel][(open_reg && any_hit) ? pick : '0]);
                end
            end
            MODE_ROWQ: qt_next = bank_ok && (hits >= MIN_FURTHER);
            MODE_REQQ: qt_next = bank_ok && (cnt >= CW'(MIN_FURTHER));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int b = 0; b < BANKS; b++) count_reg[b] <= '0;
        end else begin
            state_reg <= state_next;
            if (do_store) count_reg[bsel] <= cnt + CW'(1);
            if (do_remove) count_reg[bsel] <= cnt - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            mode_reg <= s_mode;
            bank_reg <= s_bank_index;
            row_reg  <= ROW_BITS'(s_row_address);
            tag_reg  <= TAG_BITS'(s_request_tag);
            open_reg <= s_bank_is_open;
            orow_reg <= ROW_BITS'(s_open_row);
        end
        if (exec) begin
            status_reg <= status_next;
            ctag_reg   <= ctag_next;
            crow_reg   <= crow_next;
            qt_reg     <= qt_next;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_OUT);
    assign m_status     = status_reg;
    assign m_chosen_tag = ctag_reg;
    assign m_chosen_row = crow_reg;
    assign m_query_true = qt_reg;

    `FBQ_ASSERT_IMP(a_one_side, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `FBQ_ASSERT_NEXT(a_exec_out, aclk, aresetn, exec, m_valid)
    `FBQ_ASSERT_IMP(a_no_both, aclk, aresetn, 1'b1, !(do_store && do_remove))
endmodule
